// ===== sv/urbom_pkg.sv =====
// Shared types and constants for the UART ring buffer pair with overflow notice.
// Holds the event codes, the notice ROM and the controller/datapath signal groups.
// No dependencies.
package urbom_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int DEPTH_DEF      = 512;
  localparam int MARKER_LEN_DEF = 23;

  // Widths fixed by the port list.
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 9;
  localparam int MARK_W  = 5;

  // Event codes on op.
  localparam logic [OP_W-1:0] OP_RX_BYTE  = 3'd0;
  localparam logic [OP_W-1:0] OP_TX_READY = 3'd1;
  localparam logic [OP_W-1:0] OP_HOST_WR  = 3'd2;
  localparam logic [OP_W-1:0] OP_HOST_RD  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // Receive outcome codes.
  localparam logic [1:0] RX_STORED  = 2'd0;
  localparam logic [1:0] RX_NOTICE  = 2'd1;
  localparam logic [1:0] RX_DROPPED = 2'd2;

  // Overflow notice text, zero padded to 32 bytes.
  localparam logic [BYTE_W-1:0] NOTICE_ROM [32] = '{
    8'h3C, 8'h44, 8'h41, 8'h50, 8'h4C, 8'h69, 8'h6E, 8'h6B,
    8'h3A, 8'h53, 8'h57, 8'h4F, 8'h3A, 8'h4F, 8'h76, 8'h65,
    8'h72, 8'h66, 8'h6C, 8'h6F, 8'h77, 8'h3E, 8'h0A, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // take in a new request
    logic rx_push;     // store the received byte
    logic rx_drop;     // report the received byte as dropped
    logic mark_start;  // begin writing the notice
    logic mark_step;   // write one notice byte
    logic tx_pop;      // read and advance the transmit ring
    logic tx_irq_clr;  // clear the transmit interrupt enable
    logic tx_push;     // store the host byte
    logic tx_irq_set;  // set the transmit interrupt enable
    logic rx_pop;      // read and advance the receive ring
    logic ring_clear;  // empty both rings
    logic capture;     // take the byte from memory into the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            tx_empty;
    logic            tx_full;
    logic            rx_empty;
    logic            rx_room;   // more free slots than the notice length
    logic            rx_exact;  // free slots equal the notice length
    logic            mark_last; // last notice byte is being written
  } status_t;

endpackage

// ===== sv/uart_ring_buffers_overflow_marker.sv =====
// Top level of the UART transmit/receive ring buffer pair with overflow notice.
// Joins urbom_ctrl and urbom_dp; uses urbom_pkg.
//
//   Channel   Handshake        Fields
//   request   start / busy     op, data_byte, burst_last
//   result    done (strobe)    out_valid, out_byte, write_accepted, rx_outcome,
//                              tx_irq_enabled, tx_used, rx_used, out_last
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe has been shown.
// A transmit or host read that pops a byte passes through an extra read state
// before the strobe, set by the registered read of the ring memory.
// A received byte that triggers the overflow notice writes one notice byte per
// cycle through the memory port before the strobe.
// done is high for exactly one cycle; the receiver cannot stall it.
// Reset empties both rings and clears the interrupt enable; there is no
// clearing pass, memory contents are only read once written.
module uart_ring_buffers_overflow_marker
  import urbom_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int MARKER_LEN = MARKER_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [OP_W-1:0]    op,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               burst_last,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               write_accepted,
  output logic [1:0]         rx_outcome,
  output logic               tx_irq_enabled,
  output logic [COUNT_W-1:0] tx_used,
  output logic [COUNT_W-1:0] rx_used,
  output logic               out_last
);

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  urbom_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .st    (st),
    .cmd   (cmd)
  );

  // Rings, pointers and result registers.
  urbom_dp #(
    .DEPTH      (DEPTH),
    .MARKER_LEN (MARKER_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .op             (op),
    .data_byte      (data_byte),
    .burst_last     (burst_last),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .write_accepted (write_accepted),
    .rx_outcome     (rx_outcome),
    .tx_irq_enabled (tx_irq_enabled),
    .tx_used        (tx_used),
    .rx_used        (rx_used),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  // The strobe only appears while a request is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a request");

  // The strobe lasts one cycle and frees the block.
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  // A taken request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy && !done)
    else $error("request taken but block not busy");

  // An accepted host write always leaves the interrupt enabled.
  a_wr_irq: assert property (@(posedge clk) disable iff (rst)
    (done && write_accepted) |-> tx_irq_enabled)
    else $error("accepted write without interrupt enable");
`endif

endmodule

// ===== sv/urbom_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module urbom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/urbom_dp.sv =====
// Datapath of the UART ring buffer pair: ring pointers, interrupt enable,
// both byte memories and the result registers. Uses urbom_pkg and urbom_ram.
module urbom_dp
  import urbom_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int MARKER_LEN = MARKER_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [OP_W-1:0]    op,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               burst_last,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               write_accepted,
  output logic [1:0]         rx_outcome,
  output logic               tx_irq_enabled,
  output logic [COUNT_W-1:0] tx_used,
  output logic [COUNT_W-1:0] rx_used,
  output logic               out_last
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int USED_W = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;

  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [PTR_W-1:0]  tx_head, tx_tail, rx_head, rx_tail;
  logic              tx_irq;
  logic [MARK_W-1:0] mark_cnt;
  logic              res_valid, res_acc;
  logic [BYTE_W-1:0] res_byte;
  logic [1:0]        res_outcome;
  logic [USED_W-1:0] tx_cnt, rx_cnt;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata, rx_wdata;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [USED_W-1:0] ring_used(input logic [PTR_W-1:0] head,
                                                  input logic [PTR_W-1:0] tail);
    logic [USED_W-1:0] wrap;
    wrap = (head < tail) ? USED_W'(DEPTH) : '0;
    return USED_W'(head) - USED_W'(tail) + wrap;
  endfunction

  // Fill counts and ring conditions.
  always_comb begin
    tx_cnt       = ring_used(tx_head, tx_tail);
    rx_cnt       = ring_used(rx_head, rx_tail);
    st.op        = op_q;
    st.tx_empty  = (tx_cnt == '0);
    st.tx_full   = (tx_cnt == USED_W'(DEPTH - 1));
    st.rx_empty  = (rx_cnt == '0);
    st.rx_room   = (rx_cnt < USED_W'(DEPTH - 1 - MARKER_LEN));
    st.rx_exact  = (rx_cnt == USED_W'(DEPTH - 1 - MARKER_LEN));
    st.mark_last = (mark_cnt == MARK_W'(MARKER_LEN - 1));
  end

  // Request capture and notice counter.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op;
      byte_q <= data_byte;
      last_q <= burst_last;
    end
    if (cmd.mark_start) begin
      mark_cnt <= '0;
    end else if (cmd.mark_step) begin
      mark_cnt <= mark_cnt + 1'b1;
    end
  end

  // Ring pointers and the interrupt enable.
  always_ff @(posedge clk) begin
    if (rst || cmd.ring_clear) begin
      tx_head <= '0;
      tx_tail <= '0;
      rx_head <= '0;
      rx_tail <= '0;
    end else begin
      if (cmd.tx_push) begin
        tx_head <= ring_next(tx_head);
      end
      if (cmd.tx_pop) begin
        tx_tail <= ring_next(tx_tail);
      end
      if (cmd.rx_push || cmd.mark_step) begin
        rx_head <= ring_next(rx_head);
      end
      if (cmd.rx_pop) begin
        rx_tail <= ring_next(rx_tail);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_irq <= 1'b0;
    end else if (cmd.tx_irq_set) begin
      tx_irq <= 1'b1;
    end else if (cmd.tx_irq_clr) begin
      tx_irq <= 1'b0;
    end
  end

  // Result registers, cleared when a request is taken in.
  always_ff @(posedge clk) begin
    if (rst || cmd.latch) begin
      res_valid   <= 1'b0;
      res_byte    <= '0;
      res_acc     <= 1'b0;
      res_outcome <= RX_STORED;
    end else begin
      if (cmd.capture) begin
        res_valid <= 1'b1;
        res_byte  <= (op_q == OP_TX_READY) ? tx_rdata : rx_rdata;
      end
      if (cmd.tx_push) begin
        res_acc <= 1'b1;
      end
      if (cmd.mark_start) begin
        res_outcome <= RX_NOTICE;
      end else if (cmd.rx_drop) begin
        res_outcome <= RX_DROPPED;
      end
    end
  end

  // Byte memories of the two rings.
  assign rx_wdata = cmd.mark_step ? NOTICE_ROM[mark_cnt] : byte_q;

  urbom_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (cmd.tx_push),
    .waddr (tx_head),
    .wdata (byte_q),
    .re    (cmd.tx_pop),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  urbom_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (cmd.rx_push || cmd.mark_step),
    .waddr (rx_head),
    .wdata (rx_wdata),
    .re    (cmd.rx_pop),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  // Result ports.
  assign out_valid      = res_valid;
  assign out_byte       = res_byte;
  assign write_accepted = res_acc;
  assign rx_outcome     = res_outcome;
  assign tx_irq_enabled = tx_irq;
  assign tx_used        = tx_cnt[COUNT_W-1:0];
  assign rx_used        = rx_cnt[COUNT_W-1:0];
  assign out_last       = last_q;

endmodule

// ===== sv/urbom_ctrl.sv =====
// Controller of the UART ring buffer pair: sequences each request through decode,
// a memory read or notice writing where one is needed, and the result strobe. Uses urbom_pkg.
module urbom_ctrl
  import urbom_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_MARK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (st.op)
          OP_RX_BYTE: begin
            if (st.rx_room) begin
              cmd.rx_push = 1'b1;
            end else if (st.rx_exact) begin
              cmd.mark_start = 1'b1;
              state_next     = S_MARK;
            end else begin
              cmd.rx_drop = 1'b1;
            end
          end
          OP_TX_READY: begin
            if (st.tx_empty) begin
              cmd.tx_irq_clr = 1'b1;
            end else begin
              cmd.tx_pop = 1'b1;
              state_next = S_READ;
            end
          end
          OP_HOST_WR: begin
            cmd.tx_push    = !st.tx_full;
            cmd.tx_irq_set = 1'b1;
          end
          OP_HOST_RD: begin
            if (!st.rx_empty) begin
              cmd.rx_pop = 1'b1;
              state_next = S_READ;
            end
          end
          OP_CLEAR: begin
            cmd.ring_clear = 1'b1;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (st.mark_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== verif/uart_ring_buffers_overflow_marker_tb.sv =====
// Self-checking testbench for the UART transmit/receive ring pair with overflow notice.
// Depends on urbom_pkg and uart_ring_buffers_overflow_marker; it predicts each result
// from its own copy of both rings and compares every field on the result strobe.
module uart_ring_buffers_overflow_marker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import urbom_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  localparam int NOTICE_LEN  = MARKER_LEN_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam logic [OP_W-1:0] OP_TOP_CODE = '1;

  // Text written into the receive ring when it is about to overflow.
  localparam logic [BYTE_W-1:0] OVERFLOW_TEXT [32] = '{
    8'h3C, 8'h44, 8'h41, 8'h50, 8'h4C, 8'h69, 8'h6E, 8'h6B,
    8'h3A, 8'h53, 8'h57, 8'h4F, 8'h3A, 8'h4F, 8'h76, 8'h65,
    8'h72, 8'h66, 8'h6C, 8'h6F, 8'h77, 8'h3E, 8'h0A, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic               popped;
    logic [BYTE_W-1:0]  popped_byte;
    logic               wr_ok;
    logic [1:0]         rx_code;
    logic               irq_en;
    logic [COUNT_W-1:0] tx_fill;
    logic [COUNT_W-1:0] rx_fill;
    logic               last_echo;
  } ring_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               done;
  logic [OP_W-1:0]    op = OP_RX_BYTE;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic               burst_last = 1'b0;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               write_accepted;
  logic [1:0]         rx_outcome;
  logic               tx_irq_enabled;
  logic [COUNT_W-1:0] tx_used;
  logic [COUNT_W-1:0] rx_used;
  logic               out_last;

  // Predicted state of both rings.
  logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
  logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
  int   tx_wr = 0, tx_rd = 0, rx_wr = 0, rx_rd = 0;
  logic tx_irq = 1'b0;

  // Event tallies that steer the random phases.
  int rx_notice_events = 0;
  int rx_drop_events   = 0;
  int rx_empty_reads   = 0;
  int tx_reject_events = 0;

  ring_report_t ring_reports_due [$];
  int   requests_taken = 0;
  int   reports_seen   = 0;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   request_serial = 0;
  logic idle_on        = 1'b1;

  uart_ring_buffers_overflow_marker dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .op             (op),
    .data_byte      (data_byte),
    .burst_last     (burst_last),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .write_accepted (write_accepted),
    .rx_outcome     (rx_outcome),
    .tx_irq_enabled (tx_irq_enabled),
    .tx_used        (tx_used),
    .rx_used        (rx_used),
    .out_last       (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ring arithmetic: one slot is always kept free.
  function automatic int ring_fill(input int head, input int tail);
    return (head >= tail) ? (head - tail) : (RING_DEPTH - tail + head);
  endfunction

  function automatic int ring_room(input int head, input int tail);
    return RING_DEPTH - 1 - ring_fill(head, tail);
  endfunction

  function automatic int ring_step(input int ptr);
    return (ptr + 1 >= RING_DEPTH) ? 0 : ptr + 1;
  endfunction

  function automatic logic [OP_W-1:0] pick_unknown_op();
    return OP_W'($urandom_range(OP_CLEAR + 1, OP_TOP_CODE));
  endfunction

  // Applies one request to the predicted rings and returns the report it must produce.
  task automatic advance_uart_rings(input logic [OP_W-1:0] code,
                                    input logic [BYTE_W-1:0] value,
                                    input logic last_flag,
                                    output ring_report_t rep);
    int room;
    rep = '0;
    case (code)
      OP_RX_BYTE: begin
        room = ring_room(rx_wr, rx_rd);
        if (room > NOTICE_LEN) begin
          rx_ring[rx_wr] = value;
          rx_wr = ring_step(rx_wr);
          rep.rx_code = RX_STORED;
        end else if (room == NOTICE_LEN) begin
          for (int i = 0; i < NOTICE_LEN; i++) begin
            rx_ring[rx_wr] = OVERFLOW_TEXT[i % 32];
            rx_wr = ring_step(rx_wr);
          end
          rep.rx_code = RX_NOTICE;
          rx_notice_events++;
        end else begin
          rep.rx_code = RX_DROPPED;
          rx_drop_events++;
        end
      end
      OP_TX_READY: begin
        if (ring_fill(tx_wr, tx_rd) > 0) begin
          rep.popped_byte = tx_ring[tx_rd];
          rep.popped = 1'b1;
          tx_rd = ring_step(tx_rd);
        end else begin
          tx_irq = 1'b0;
        end
      end
      OP_HOST_WR: begin
        if (ring_room(tx_wr, tx_rd) > 0) begin
          tx_ring[tx_wr] = value;
          tx_wr = ring_step(tx_wr);
          rep.wr_ok = 1'b1;
        end else begin
          tx_reject_events++;
        end
        tx_irq = 1'b1;
      end
      OP_HOST_RD: begin
        if (ring_fill(rx_wr, rx_rd) > 0) begin
          rep.popped_byte = rx_ring[rx_rd];
          rep.popped = 1'b1;
          rx_rd = ring_step(rx_rd);
        end else begin
          rx_empty_reads++;
        end
      end
      OP_CLEAR: begin
        tx_wr = 0;
        tx_rd = 0;
        rx_wr = 0;
        rx_rd = 0;
      end
      default: ;
    endcase
    rep.irq_en    = tx_irq;
    rep.tx_fill   = COUNT_W'(ring_fill(tx_wr, tx_rd));
    rep.rx_fill   = COUNT_W'(ring_fill(rx_wr, rx_rd));
    rep.last_echo = last_flag;
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR t=%0t result %0d: %s", $time, reports_seen, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Takes each request into the prediction and compares each result with the oldest one due.
  always @(posedge clk) begin
    ring_report_t due;
    ring_report_t fresh;
    if (!rst) begin
      if (done) begin
        if (ring_reports_due.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          due = ring_reports_due.pop_front();
          check_field("out_valid", out_valid, due.popped);
          check_field("out_byte", out_byte, due.popped_byte);
          check_field("write_accepted", write_accepted, due.wr_ok);
          check_field("rx_outcome", rx_outcome, due.rx_code);
          check_field("tx_irq_enabled", tx_irq_enabled, due.irq_en);
          check_field("tx_used", tx_used, due.tx_fill);
          check_field("rx_used", rx_used, due.rx_fill);
          check_field("out_last", out_last, due.last_echo);
        end
        reports_seen++;
      end
      if (start && !busy) begin
        advance_uart_rings(op, data_byte, burst_last, fresh);
        ring_reports_due.push_back(fresh);
        requests_taken++;
      end
    end
  end

  // The run is cut short if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one request after an optional gap and returns once it has been taken.
  task automatic send_request(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] value,
                              input logic last_flag);
    int gap;
    int roll;
    int taken_before;
    if (request_serial % 40 == 0)
      idle_on = ($urandom_range(0, 3) != 0);
    request_serial++;
    gap = 0;
    if (idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90)
        gap = $urandom_range(8, 60);
      else if (roll >= 45)
        gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    op         <= code;
    data_byte  <= value;
    burst_last <= last_flag;
    taken_before = requests_taken;
    do @(negedge clk); while (requests_taken == taken_before);
  endtask

  task automatic send_random_payload(input logic [OP_W-1:0] code);
    send_request(code, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Empty rings, byte extremes, every event code and the interrupt enable rules.
  task automatic test_directed();
    send_request(OP_TX_READY, 8'hFF, 1'b1);
    send_request(OP_HOST_RD, 8'hFF, 1'b0);
    send_request(OP_HOST_WR, 8'h00, 1'b0);
    send_request(OP_HOST_WR, 8'hFF, 1'b1);
    send_request(OP_HOST_WR, 8'hA5, 1'b0);
    send_request(OP_TX_READY, 8'h00, 1'b1);
    send_request(OP_RX_BYTE, 8'h00, 1'b0);
    send_request(OP_RX_BYTE, 8'hFF, 1'b1);
    send_request(OP_HOST_RD, 8'h00, 1'b0);
    send_request(OP_CLEAR + 3'd1, 8'hFF, 1'b1);
    send_request(OP_TOP_CODE - 3'd1, 8'h3C, 1'b0);
    send_request(OP_TOP_CODE, 8'h00, 1'b1);
    // Clearing keeps the interrupt enable; an empty transmit ring then drops it.
    send_request(OP_CLEAR, 8'h77, 1'b0);
    send_request(OP_TX_READY, 8'h11, 1'b0);
    send_request(OP_HOST_RD, 8'h22, 1'b1);
    send_request(OP_HOST_WR, 8'h5A, 1'b1);
    send_request(OP_CLEAR, 8'h00, 1'b1);
    send_request(OP_RX_BYTE, 8'h81, 1'b0);
    send_request(OP_HOST_RD, 8'h7E, 1'b1);
    send_request(OP_HOST_RD, 8'h00, 1'b0);
  endtask

  // Weighted random traffic over all codes, with an occasional clear.
  task automatic test_random_mix(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)      send_random_payload(OP_RX_BYTE);
      else if (roll < 40) send_random_payload(OP_TX_READY);
      else if (roll < 65) send_random_payload(OP_HOST_WR);
      else if (roll < 85) send_random_payload(OP_HOST_RD);
      else if (roll < 88) send_random_payload(OP_CLEAR);
      else                send_random_payload(pick_unknown_op());
    end
  endtask

  // Fills the receive ring until the notice goes in and further bytes are dropped.
  task automatic test_rx_overflow();
    int notices_before;
    int drops_before;
    int guard;
    int roll;
    notices_before = rx_notice_events;
    drops_before   = rx_drop_events;
    guard = 0;
    while ((rx_notice_events == notices_before || rx_drop_events < drops_before + 3) &&
           guard < 3000) begin
      roll = $urandom_range(0, 99);
      // With too little room for the notice, reads are needed before it can fire.
      if (rx_notice_events == notices_before && ring_room(rx_wr, rx_rd) < NOTICE_LEN)
        send_random_payload(OP_HOST_RD);
      else if (roll < 65)
        send_random_payload(OP_RX_BYTE);
      else if (roll < 95)
        send_random_payload(OP_HOST_WR);
      else
        send_random_payload(pick_unknown_op());
      guard++;
    end
  endtask

  // Reads the receive ring dry, notice included, while host writes fill the transmit ring.
  task automatic test_rx_drain_tx_full();
    int empties_before;
    int rejects_before;
    int guard;
    int roll;
    empties_before = rx_empty_reads;
    rejects_before = tx_reject_events;
    guard = 0;
    while ((ring_fill(rx_wr, rx_rd) != 0 || rx_empty_reads < empties_before + 2 ||
            tx_reject_events < rejects_before + 3) && guard < 4000) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)      send_random_payload(OP_HOST_RD);
      else if (roll < 95) send_random_payload(OP_HOST_WR);
      else                send_random_payload(pick_unknown_op());
      guard++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(150);
    test_rx_overflow();
    test_rx_drain_tx_full();
    test_random_mix(100);
    start <= 1'b0;
    // Let every outstanding result arrive, then watch for stray strobes.
    while (ring_reports_due.size() != 0) @(negedge clk);
    repeat (NOTICE_LEN + 8) @(negedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
